// File: rtl/smvlq_pkg.sv
// Shared types and constants for the source map VLQ line decoder.
package smvlq_pkg;

  // Character codes of the base64 alphabet and the separators
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  localparam logic [5:0] DIG_LOWER_BASE = 6'd26;
  localparam logic [5:0] DIG_NUM_BASE   = 6'd52;
  localparam logic [5:0] DIG_PLUS       = 6'd62;
  localparam logic [5:0] DIG_SLASH      = 6'd63;

  localparam int         DIGIT_BITS = 5;
  localparam int         ACC_W      = 32;
  localparam logic [5:0] SHIFT_STEP = 6'd5;

  localparam logic [2:0] POS_MAX      = 3'd5;
  localparam logic [2:0] POS_LINE     = 3'd2;
  localparam logic [2:0] POS_EMIT_MIN = 3'd4;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_ERROR = 1'b1
  } smvlq_kind_t;

  // One classified character as held in the queue
  typedef struct packed {
    logic       first;
    logic       semi;
    logic       comma;
    logic       bad;
    logic [5:0] digit;
  } smvlq_item_t;

endpackage

// File: rtl/smvlq_if.sv
// Valid/ready channel interfaces for the character input and the result output.
interface smvlq_in_if;
  logic       valid;
  logic       ready;
  logic       first;
  logic [7:0] char_code;

  modport source (output valid, output first, output char_code, input ready);
  modport sink   (input valid, input first, input char_code, output ready);
endinterface

interface smvlq_out_if #(parameter int LINE_BITS = 20);
  import smvlq_pkg::*;
  logic                valid;
  logic                ready;
  smvlq_kind_t         kind;
  logic [LINE_BITS:0]  table_index;
  logic signed [31:0]  source_line;

  modport source (output valid, output kind, output table_index, output source_line,
                  input ready);
  modport sink   (input valid, input kind, input table_index, input source_line,
                  output ready);
endinterface

// File: rtl/source_map_line_vlq_decoder.sv
// Top level of the source map mappings VLQ line decoder.
// Each character passes through the front-end queue and then the back end's registered result stage.
// Throughput: one character per cycle while the output is not back-pressured, set by the back end's state update.
// Input is refused only while the two-entry queue is full under output back-pressure.
// Reset (rst_n low, synchronous): queue emptied, decoding state and line_limit cleared.
module source_map_line_vlq_decoder #(
  parameter int LINE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  smvlq_in_if.sink             in_ch,
  smvlq_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [LINE_BITS-1:0] cfg_wdata
);
  import smvlq_pkg::*;

  logic [LINE_BITS-1:0] line_limit_r;
  smvlq_item_t          q_item;
  logic                 q_valid;
  logic                 q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_limit_r <= '0;
    end else if (cfg_we) begin
      line_limit_r <= cfg_wdata;
    end
  end

  smvlq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  smvlq_back #(
    .LINE_BITS (LINE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .line_limit (line_limit_r),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/smvlq_front.sv
// Front end: base64 classification of each character and a two-entry queue.
module smvlq_front (
  input  logic               clk,
  input  logic               rst_n,
  smvlq_in_if.sink           in_ch,
  output smvlq_pkg::smvlq_item_t q_item,
  output logic               q_valid,
  input  logic               q_pop
);
  import smvlq_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  smvlq_item_t             qmem [QDEPTH];
  smvlq_item_t             cls;
  logic [PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    push;

  always_comb begin
    cls.first = in_ch.first;
    cls.semi  = (in_ch.char_code == CH_SEMI);
    cls.comma = (in_ch.char_code == CH_COMMA);
    cls.bad   = 1'b0;
    cls.digit = '0;
    case (in_ch.char_code) inside
      [CH_UPPER_A:CH_UPPER_Z]: cls.digit = 6'(in_ch.char_code - CH_UPPER_A);
      [CH_LOWER_A:CH_LOWER_Z]: cls.digit = 6'(in_ch.char_code - CH_LOWER_A) + DIG_LOWER_BASE;
      [CH_ZERO:CH_NINE]:       cls.digit = 6'(in_ch.char_code - CH_ZERO) + DIG_NUM_BASE;
      CH_PLUS:                 cls.digit = DIG_PLUS;
      CH_SLASH:                cls.digit = DIG_SLASH;
      // outside the alphabet: decoded as digit 0
      default:                 cls.bad   = 1'b1;
    endcase
  end

  assign in_ch.ready = (count_r != CNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_item      = qmem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/smvlq_back.sv
// Back end: VLQ assembly, segment field tracking and the registered result stage.
module smvlq_back #(
  parameter int LINE_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  smvlq_pkg::smvlq_item_t q_item,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  logic [LINE_BITS-1:0]   line_limit,
  smvlq_out_if.source            out_ch
);
  import smvlq_pkg::*;

  localparam int GEN_W  = LINE_BITS + 1;
  localparam int WIDE_W = ACC_W + DIGIT_BITS;

  logic [2:0]        pos_r, pos_nxt, pos_c;
  logic [GEN_W-1:0]  gen_r, gen_nxt, gen_c;
  logic [ACC_W-1:0]  sum_r, sum_nxt, sum_c;
  logic [ACC_W-1:0]  acc_r, acc_nxt, acc_c;
  logic [5:0]        shift_r, shift_nxt, shift_c;
  logic              pend_r, pend_nxt, pend_c;

  logic [WIDE_W-1:0] dig_wide;
  logic [ACC_W-1:0]  acc_new, mag;
  logic              emit;
  smvlq_kind_t       kind_c;
  logic [GEN_W-1:0]  idx_c;
  logic [ACC_W-1:0]  src_c;

  logic              out_valid_r;
  smvlq_kind_t       kind_r;
  logic [GEN_W-1:0]  idx_r;
  logic [ACC_W-1:0]  src_r;
  logic              fire;

  assign fire  = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop = fire;

  always_comb begin
    // a first-flagged transaction starts from cleared decoding state
    pos_c   = q_item.first ? '0 : pos_r;
    gen_c   = q_item.first ? '0 : gen_r;
    sum_c   = q_item.first ? '0 : sum_r;
    acc_c   = q_item.first ? '0 : acc_r;
    shift_c = q_item.first ? '0 : shift_r;
    pend_c  = q_item.first ? 1'b0 : pend_r;

    pos_nxt   = pos_c;
    gen_nxt   = gen_c;
    sum_nxt   = sum_c;
    acc_nxt   = acc_c;
    shift_nxt = shift_c;
    pend_nxt  = pend_c;

    emit   = 1'b0;
    kind_c = KIND_WRITE;
    idx_c  = '0;
    src_c  = '0;

    // earlier digits sit below the shift, so the new digit merges by OR
    dig_wide = WIDE_W'(q_item.digit[DIGIT_BITS-1:0]) << shift_c[4:0];
    acc_new  = shift_c[5] ? acc_c : (acc_c | dig_wide[ACC_W-1:0]);
    mag      = {1'b0, acc_new[ACC_W-1:1]};

    if (!pend_c && (q_item.semi || q_item.comma)) begin
      if (pos_c >= POS_EMIT_MIN && gen_c < GEN_W'(line_limit)) begin
        emit  = 1'b1;
        idx_c = gen_c + GEN_W'(1);
        src_c = sum_c + ACC_W'(1);
      end
      if (q_item.semi && gen_c != '1) begin
        gen_nxt = gen_c + GEN_W'(1);
      end
      pos_nxt = '0;
    end else begin
      if (!shift_c[5]) begin
        acc_nxt   = acc_new;
        shift_nxt = shift_c + SHIFT_STEP;
      end
      if (q_item.digit[DIGIT_BITS]) begin
        pend_nxt = 1'b1;
      end else begin
        if (pos_c == POS_LINE) begin
          sum_nxt = acc_new[0] ? (sum_c - mag) : (sum_c + mag);
        end
        if (pos_c < POS_MAX) begin
          pos_nxt = pos_c + 3'd1;
        end
        acc_nxt   = '0;
        shift_nxt = '0;
        pend_nxt  = 1'b0;
      end
      if (q_item.bad) begin
        emit   = 1'b1;
        kind_c = KIND_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      gen_r       <= '0;
      sum_r       <= '0;
      acc_r       <= '0;
      shift_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        pos_r       <= pos_nxt;
        gen_r       <= gen_nxt;
        sum_r       <= sum_nxt;
        acc_r       <= acc_nxt;
        shift_r     <= shift_nxt;
        pend_r      <= pend_nxt;
        out_valid_r <= emit;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      kind_r <= kind_c;
      idx_r  <= idx_c;
      src_r  <= src_c;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = kind_r;
  assign out_ch.table_index = idx_r;
  assign out_ch.source_line = $signed(src_r);

endmodule

// File: verif/tb.sv
// Testbench for the source map VLQ line decoder: a directed table, then random mappings text.
module tb;
  import smvlq_pkg::*;

  localparam int LINE_BITS     = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 60;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    smvlq_kind_t        kind;
    logic [LINE_BITS:0] table_index;
    logic signed [31:0] source_line;
  } decoder_result_t;

  typedef struct packed {
    logic       first;
    logic [7:0] char_code;
  } char_item_t;

  typedef struct packed {
    logic            first;
    logic [7:0]      char_code;
    logic            typed;
    decoder_result_t result;
  } stim_row_t;

  localparam decoder_result_t NO_RESULT = '{kind: KIND_WRITE, table_index: '0, source_line: '0};
  localparam decoder_result_t BAD_CHAR  = '{kind: KIND_ERROR, table_index: '0, source_line: '0};

  // Walked with line_limit at 3; only the error rows carry a typed result
  localparam stim_row_t DIRECTED_ROWS [26] = '{
    '{1'b1, "A",       1'b0, NO_RESULT},
    '{1'b0, "A",       1'b0, NO_RESULT},
    '{1'b0, "D",       1'b0, NO_RESULT},   // -1 into the source line sum
    '{1'b0, "A",       1'b0, NO_RESULT},
    '{1'b0, CH_COMMA,  1'b0, NO_RESULT},   // four fields: table write
    '{1'b0, "g",       1'b0, NO_RESULT},   // continuation digit
    '{1'b0, CH_SEMI,   1'b1, BAD_CHAR},    // separator swallowed as a digit
    '{1'b0, "A",       1'b0, NO_RESULT},
    '{1'b0, CH_SLASH,  1'b0, NO_RESULT},
    '{1'b0, CH_SLASH,  1'b0, NO_RESULT},
    '{1'b0, CH_SLASH,  1'b0, NO_RESULT},
    '{1'b0, CH_SLASH,  1'b0, NO_RESULT},
    '{1'b0, CH_SLASH,  1'b0, NO_RESULT},
    '{1'b0, CH_SLASH,  1'b0, NO_RESULT},
    '{1'b0, CH_SLASH,  1'b0, NO_RESULT},   // shift now past 32
    '{1'b0, CH_SLASH,  1'b0, NO_RESULT},   // bits dropped
    '{1'b0, "f",       1'b0, NO_RESULT},
    '{1'b0, "E",       1'b0, NO_RESULT},
    '{1'b0, "B",       1'b0, NO_RESULT},
    '{1'b0, "Z",       1'b0, NO_RESULT},   // sixth field, position stays at 5
    '{1'b0, CH_SEMI,   1'b0, NO_RESULT},
    '{1'b1, 8'h00,     1'b1, BAD_CHAR},
    '{1'b0, 8'hFF,     1'b1, BAD_CHAR},
    '{1'b0, CH_PLUS,   1'b0, NO_RESULT},
    '{1'b0, "a",       1'b0, NO_RESULT},
    '{1'b0, CH_SEMI,   1'b0, NO_RESULT}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [LINE_BITS-1:0] cfg_wdata;

  smvlq_in_if                            in_ch ();
  smvlq_out_if #(.LINE_BITS(LINE_BITS))  out_ch ();

  source_map_line_vlq_decoder #(.LINE_BITS(LINE_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the decoder state
  logic [LINE_BITS-1:0] limit_shadow;
  logic [2:0]           field_no;
  logic [LINE_BITS:0]   gen_line;
  logic [31:0]          line_sum;
  logic [31:0]          vlq_acc;
  logic [5:0]           acc_shift;
  logic                 mid_value;

  decoder_result_t results_due [$];
  char_item_t      text_q [$];
  logic            fresh_string;
  logic            hold_wanted;
  int              failures = 0;
  int              quiet_cycles = 0;
  int              send_idle_pct;
  int              recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void report_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  function automatic void clear_decoding_state();
    field_no  = '0;
    gen_line  = '0;
    line_sum  = '0;
    vlq_acc   = '0;
    acc_shift = '0;
    mid_value = 1'b0;
  endfunction

  function automatic logic decode_char(input logic first, input logic [7:0] c,
                                       output decoder_result_t res);
    logic [5:0]  digit;
    logic        bad;
    logic        emit;
    logic [31:0] mag;
    logic [31:0] val;
    res   = NO_RESULT;
    emit  = 1'b0;
    bad   = 1'b0;
    digit = '0;
    if (first) clear_decoding_state();
    if (!mid_value && (c == CH_SEMI || c == CH_COMMA)) begin
      if (field_no >= POS_EMIT_MIN && gen_line < {1'b0, limit_shadow}) begin
        res = '{kind: KIND_WRITE, table_index: gen_line + 1'b1, source_line: line_sum + 1};
        emit = 1'b1;
      end
      if (c == CH_SEMI && gen_line != '1) gen_line = gen_line + 1'b1;
      field_no = '0;
      return emit;
    end
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      digit = 6'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      digit = 6'(c - CH_LOWER_A) + DIG_LOWER_BASE;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      digit = 6'(c - CH_ZERO) + DIG_NUM_BASE;
    end else if (c == CH_PLUS) begin
      digit = DIG_PLUS;
    end else if (c == CH_SLASH) begin
      digit = DIG_SLASH;
    end else begin
      bad = 1'b1;   // taken as digit 0, which closes the value
    end
    if (acc_shift < ACC_W) begin
      vlq_acc   = vlq_acc + (32'(digit[DIGIT_BITS-1:0]) << acc_shift);
      acc_shift = acc_shift + SHIFT_STEP;
    end
    if (digit[DIGIT_BITS]) begin
      mid_value = 1'b1;
    end else begin
      mag = vlq_acc >> 1;
      val = vlq_acc[0] ? 32'd0 - mag : mag;
      if (field_no == POS_LINE) line_sum = line_sum + val;
      if (field_no < POS_MAX) field_no = field_no + 1'b1;
      vlq_acc   = '0;
      acc_shift = '0;
      mid_value = 1'b0;
    end
    if (bad) begin
      res  = BAD_CHAR;
      emit = 1'b1;
    end
    return emit;
  endfunction

  // Offers one character; returns at the edge where the transaction is taken
  task automatic send_char(input logic first, input logic [7:0] c, input logic typed,
                           input decoder_result_t typed_res);
    decoder_result_t res;
    logic            emit;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.first     <= first;
    in_ch.char_code <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    emit = decode_char(first, c, res);
    if (typed) results_due.push_back(typed_res);
    else if (emit) results_due.push_back(res);
  endtask

  task automatic set_line_limit(input logic [LINE_BITS-1:0] value);
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    limit_shadow = value;
  endtask

  function automatic void queue_char(input logic [7:0] c);
    text_q.push_back('{first: fresh_string, char_code: c});
    fresh_string = 1'b0;
  endfunction

  function automatic void queue_value();
    logic [32:0] vlq;
    logic [31:0] mag;
    logic [5:0]  digit;
    logic [7:0]  c;
    int          pick;
    int          chunks;
    int          total;
    int          stop;
    pick = $urandom_range(99);
    if (pick < 65) mag = $urandom_range(40);
    else if (pick < 88) mag = $urandom_range(200000);
    else mag = $urandom();
    vlq = {mag, 1'($urandom_range(1))};
    chunks = 1;
    while ((vlq >> (DIGIT_BITS * chunks)) != 0) chunks++;
    // now and then run on with extra digits, into the bits that get dropped
    total = chunks + (($urandom_range(99) < 4) ? $urandom_range(1, 4) : 0);
    // or break off before the last digit so a separator lands mid-value
    stop = (total > 1 && $urandom_range(99) < 4) ? total - 1 : total;
    for (int i = 0; i < stop; i++) begin
      digit[DIGIT_BITS-1:0] = (i < chunks) ? 5'(vlq >> (DIGIT_BITS * i))
                                           : 5'($urandom_range(31));
      digit[DIGIT_BITS] = (i < total - 1);
      if (digit < DIG_LOWER_BASE) c = CH_UPPER_A + digit;
      else if (digit < DIG_NUM_BASE) c = CH_LOWER_A + (digit - DIG_LOWER_BASE);
      else if (digit < DIG_PLUS) c = CH_ZERO + (digit - DIG_NUM_BASE);
      else if (digit == DIG_PLUS) c = CH_PLUS;
      else c = CH_SLASH;
      queue_char(c);
    end
  endfunction

  function automatic void queue_segment();
    int         n;
    int         pick;
    logic [7:0] sep;
    fresh_string = ($urandom_range(99) < 2);
    pick = $urandom_range(99);
    if (pick < 45) n = 4;
    else if (pick < 75) n = 5;
    else if (pick < 85) n = 1;
    else n = $urandom_range(6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) queue_char(8'($urandom_range(255)));
      queue_value();
    end
    sep = ($urandom_range(99) < 35) ? CH_SEMI : CH_COMMA;
    queue_char(sep);
    if (sep == CH_SEMI && $urandom_range(99) < 10) queue_char(CH_SEMI);
  endfunction

  task automatic run_random(input int count);
    char_item_t item;
    text_q.delete();
    repeat (count) begin
      if (text_q.size() == 0) queue_segment();
      item = text_q.pop_front();
      send_char(item.first, item.char_code, 1'b0, NO_RESULT);
    end
  endtask

  // Result side: checks each transaction and drives ready
  initial begin
    decoder_result_t want;
    int              hold_left;
    logic            hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          report_failure($sformatf("unexpected result: kind %0d index %0d line %0d",
                                   out_ch.kind, out_ch.table_index, out_ch.source_line));
        end else begin
          want = results_due.pop_front();
          if (out_ch.kind !== want.kind || out_ch.table_index !== want.table_index ||
              out_ch.source_line !== want.source_line) begin
            report_failure($sformatf(
              "mismatch: expected kind %0d index %0d line %0d, got kind %0d index %0d line %0d",
              want.kind, want.table_index, want.source_line,
              out_ch.kind, out_ch.table_index, out_ch.source_line));
          end
        end
      end
      if (hold_wanted && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.first     <= 1'b0;
    in_ch.char_code <= '0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    hold_wanted     <= 1'b0;
    recv_idle_pct   <= 78;
    send_idle_pct   = 9;
    limit_shadow    = '0;
    clear_decoding_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    set_line_limit(LINE_BITS'(3));
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      send_char(DIRECTED_ROWS[i].first, DIRECTED_ROWS[i].char_code,
                DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
    end

    set_line_limit('1);
    run_random(240);

    send_idle_pct = 78;
    recv_idle_pct <= 9;
    set_line_limit(LINE_BITS'($urandom_range(1, 6)));
    run_random(220);
    set_line_limit('0);
    run_random(120);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    set_line_limit(LINE_BITS'(1));
    hold_wanted <= 1'b1;   // long back-pressure while characters keep coming
    run_random(120);
    set_line_limit(LINE_BITS'($urandom_range(2, (1 << LINE_BITS) - 1)));
    run_random(150);

    in_ch.valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && results_due.size() != 0; k++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      report_failure($sformatf("%0d expected results never arrived", results_due.size()));
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
